// ===== rtl/core/euler_to_rotation_matrix_defines.svh =====
// Assertion macros shared by the rotation matrix RTL.
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define E2R_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define E2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/e2r_pkg.sv =====
// Package with CORDIC constants for the rotation matrix block.
package e2r_pkg;
	localparam int CORDIC_STEPS = 32;
	localparam int CORDIC_W = 36;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 36'sd2608131496;

	typedef logic signed [CORDIC_W-1:0] cw_t;

	function automatic cw_t atan_entry(input logic [4:0] i);
		cw_t r;
		r = '0;
		case (i)
			5'd0: r = 36'sh020000000; 5'd1: r = 36'sh012E4051E;
			5'd2: r = 36'sh009FB385B; 5'd3: r = 36'sh0051111D4;
			5'd4: r = 36'sh0028B0D43; 5'd5: r = 36'sh00145D7E1;
			5'd6: r = 36'sh000A2F61E; 5'd7: r = 36'sh000517C55;
			5'd8: r = 36'sh00028BE53; 5'd9: r = 36'sh000145F2F;
			5'd10: r = 36'sh0000A2F98; 5'd11: r = 36'sh0000517CC;
			5'd12: r = 36'sh000028BE6; 5'd13: r = 36'sh0000145F3;
			5'd14: r = 36'sh00000A2FA; 5'd15: r = 36'sh00000517D;
			5'd16: r = 36'sh0000028BE; 5'd17: r = 36'sh00000145F;
			5'd18: r = 36'sh000000A30; 5'd19: r = 36'sh000000518;
			5'd20: r = 36'sh00000028C; 5'd21: r = 36'sh000000146;
			5'd22: r = 36'sh0000000A3; 5'd23: r = 36'sh000000051;
			5'd24: r = 36'sh000000029; 5'd25: r = 36'sh000000014;
			5'd26: r = 36'sh00000000A; 5'd27: r = 36'sh000000005;
			5'd28: r = 36'sh000000003; 5'd29: r = 36'sh000000001;
			5'd30: r = 36'sh000000001; default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/core/e2r_sincos.sv =====
// Pipelined CORDIC: sine and cosine of one binary angle, four steps per stage.
module e2r_sincos #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic adv,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic signed [FRAC_BITS+1:0] sin_o,
	output logic signed [FRAC_BITS+1:0] cos_o
);
	import e2r_pkg::*;
	localparam int GRP = 4;
	localparam int NST = CORDIC_STEPS / GRP;
	localparam int SH = 32 - FRAC_BITS;

	cw_t x_s[NST+1];
	cw_t y_s[NST+1];
	cw_t z_s[NST+1];
	logic flip_s[NST+1];

	logic [31:0] u0;
	logic fl0;
	always_comb begin
		u0 = {angle, {(32-ANGLE_BITS){1'b0}}};
		fl0 = u0[31] ^ u0[30];
		if (fl0) u0 = u0 + 32'h80000000;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= cw_t'($signed(u0));
			flip_s[0] <= fl0;
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_st
		cw_t xn, yn, zn;
		always_comb begin
			cw_t xt, yt, zt, nx;
			xt = x_s[g]; yt = y_s[g]; zt = z_s[g];
			for (int k = 0; k < GRP; k++) begin
				if (!zt[CORDIC_W-1]) begin
					nx = xt - (yt >>> (g*GRP+k));
					yt = yt + (xt >>> (g*GRP+k));
					zt = zt - atan_entry(5'(g*GRP+k));
				end else begin
					nx = xt + (yt >>> (g*GRP+k));
					yt = yt - (xt >>> (g*GRP+k));
					zt = zt + atan_entry(5'(g*GRP+k));
				end
				xt = nx;
			end
			xn = xt; yn = yt; zn = zt;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[g+1] <= xn;
				y_s[g+1] <= yn;
				z_s[g+1] <= zn;
				flip_s[g+1] <= flip_s[g];
			end
		end
	end

	function automatic logic signed [FRAC_BITS+1:0] rnd(input cw_t v, input logic neg);
		cw_t t, r;
		t = neg ? -v : v;
		r = (t + (cw_t'(1) <<< (SH-1))) >>> SH;
		if (r > cw_t'(1) <<< FRAC_BITS) r = cw_t'(1) <<< FRAC_BITS;
		if (r < -(cw_t'(1) <<< FRAC_BITS)) r = -(cw_t'(1) <<< FRAC_BITS);
		return r[FRAC_BITS+1:0];
	endfunction

	assign cos_o = rnd(x_s[NST], flip_s[NST]);
	assign sin_o = rnd(y_s[NST], flip_s[NST]);
endmodule

// ===== rtl/core/euler_to_rotation_matrix.sv =====
// Top level: Euler angles to a 3x3 rotation matrix, fully pipelined.
//
// channel  direction  handshake        payload
// in       input      in_valid/ready   pitch_angle, yaw_angle, roll_angle
// out      output     out_valid/ready  m00..m22
//
// One item per cycle while the output is not stalled; the pipe is 1 capture, 8 CORDIC
// stages of four steps, 3 product stages and 1 output register.
// Reset clears only the valid bits; payload registers hold garbage.
// The whole pipe advances when the output register is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
`include "euler_to_rotation_matrix_defines.svh"
module euler_to_rotation_matrix #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ANGLE_BITS-1:0] pitch_angle,
	input  logic [ANGLE_BITS-1:0] yaw_angle,
	input  logic [ANGLE_BITS-1:0] roll_angle,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [FRAC_BITS+1:0] m00,
	output logic signed [FRAC_BITS+1:0] m01,
	output logic signed [FRAC_BITS+1:0] m02,
	output logic signed [FRAC_BITS+1:0] m10,
	output logic signed [FRAC_BITS+1:0] m11,
	output logic signed [FRAC_BITS+1:0] m12,
	output logic signed [FRAC_BITS+1:0] m20,
	output logic signed [FRAC_BITS+1:0] m21,
	output logic signed [FRAC_BITS+1:0] m22
);
	import e2r_pkg::*;
	localparam int W = FRAC_BITS + 2;
	localparam int PW = 2*W + 1;
	localparam int CLAT = 9;            // capture + 8 CORDIC stages
	localparam int LAT = CLAT + 3;      // then three product stages
	typedef logic signed [W-1:0] q_t;
	typedef logic signed [PW-1:0] p_t;

	logic adv;
	logic [LAT-1:0] vld_q;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
			out_valid <= vld_q[LAT-1];
		end
	end

	q_t ps, pc, ys, yc, rs, rc;
	e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_p (
		.clk(clk), .adv(adv), .angle(pitch_angle), .sin_o(ps), .cos_o(pc));
	e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_y (
		.clk(clk), .adv(adv), .angle(yaw_angle), .sin_o(ys), .cos_o(yc));
	e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_r (
		.clk(clk), .adv(adv), .angle(roll_angle), .sin_o(rs), .cos_o(rc));

	// Round at FRAC_BITS, then clamp to plus or minus one.
	function automatic q_t rc1(input p_t v);
		p_t r;
		r = (v + (p_t'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
		if (r > p_t'(1) <<< FRAC_BITS) r = p_t'(1) <<< FRAC_BITS;
		if (r < -(p_t'(1) <<< FRAC_BITS)) r = -(p_t'(1) <<< FRAC_BITS);
		return r[W-1:0];
	endfunction
	function automatic p_t mx(input q_t a, input q_t b);
		return p_t'(a) * p_t'(b);
	endfunction

	// Stage A: register sines/cosines, m12 as -ps, inner products ps*ys, ps*yc.
	q_t pc_s1, ys_s1, yc_s1, rs_s1, rc_s1, m12_s1, psys_s1, psyc_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s1 <= pc; ys_s1 <= ys; yc_s1 <= yc; rs_s1 <= rs; rc_s1 <= rc;
			m12_s1 <= rc1(-(p_t'(ps) <<< FRAC_BITS));
			psys_s1 <= rc1(mx(ps, ys));
			psyc_s1 <= rc1(mx(ps, yc));
		end
	end

	// Stage B: all raw products.
	p_t a0_s2, b0_s2, a1_s2, b1_s2, a6_s2, b6_s2, a7_s2, b7_s2;
	p_t p2_s2, p3_s2, p4_s2, p8_s2;
	q_t m12_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			a0_s2 <= mx(rc_s1, yc_s1);  b0_s2 <= mx(rs_s1, psys_s1);
			a1_s2 <= -mx(rs_s1, yc_s1); b1_s2 <= mx(rc_s1, psys_s1);
			a6_s2 <= -mx(rc_s1, ys_s1); b6_s2 <= mx(rs_s1, psyc_s1);
			a7_s2 <= mx(rs_s1, ys_s1);  b7_s2 <= mx(rc_s1, psyc_s1);
			p2_s2 <= mx(pc_s1, ys_s1);  p3_s2 <= mx(rs_s1, pc_s1);
			p4_s2 <= mx(rc_s1, pc_s1);  p8_s2 <= mx(pc_s1, yc_s1);
			m12_s2 <= m12_s1;
		end
	end

	// Stage C: sum pairs, round and clamp.
	q_t r_s3[9];
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s3[0] <= rc1(a0_s2 + b0_s2);
			r_s3[1] <= rc1(a1_s2 + b1_s2);
			r_s3[2] <= rc1(p2_s2);
			r_s3[3] <= rc1(p3_s2);
			r_s3[4] <= rc1(p4_s2);
			r_s3[5] <= m12_s2;
			r_s3[6] <= rc1(a6_s2 + b6_s2);
			r_s3[7] <= rc1(a7_s2 + b7_s2);
			r_s3[8] <= rc1(p8_s2);
		end
	end

	// Output register: hold until taken.
	always_ff @(posedge clk) begin
		if (adv) begin
			m00 <= r_s3[0]; m01 <= r_s3[1]; m02 <= r_s3[2];
			m10 <= r_s3[3]; m11 <= r_s3[4]; m12 <= r_s3[5];
			m20 <= r_s3[6]; m21 <= r_s3[7]; m22 <= r_s3[8];
		end
	end

	`E2R_ASSERT_IMPL(a_ready_when_free, !out_valid, in_ready, "in_ready low while output empty")
	`E2R_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(m00) && $stable(m22), "stalled result changed")
	`E2R_ASSERT_NEXT(a_pipe_emerges, adv && vld_q[LAT-1], out_valid, "item lost at pipe tail")
endmodule

// ===== tb/euler_to_rotation_matrix_test.sv =====
// Testbench for the Euler-angle to rotation matrix pipeline.
module euler_to_rotation_matrix_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AB = 16;
	localparam int FB = 16;
	localparam int OW = FB + 2;
	localparam int LATENCY = 13;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef logic signed [OW-1:0] elem_t;
	typedef struct packed {
		elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [AB-1:0] pitch_angle = '0;
	logic [AB-1:0] yaw_angle = '0;
	logic [AB-1:0] roll_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	matrix_t expected_matrices[$];
	int mismatches = 0;
	int matrices_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	bit sink_idle_on = 1'b1;
	bit sink_hold = 1'b0;
	bit src_idle_on = 1'b1;

	euler_to_rotation_matrix #(.ANGLE_BITS(AB), .FRAC_BITS(FB)) dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Floor shift, the same as an arithmetic right shift.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat_one(longint v);
		longint one;
		one = longint'(1) << FB;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	function automatic longint rnd(longint v, int s);
		return floor_shift(v + (longint'(1) << (s - 1)), s);
	endfunction

	function automatic longint arctan_step(int i);
		longint t[32] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
			'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
			'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
			'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
			'h00000001, 'h00000000};
		return t[i];
	endfunction

	// Rotation-mode CORDIC on a 32-bit turn; folds the back half-plane forward.
	task automatic angle_sincos(input logic [AB-1:0] ang, output longint s, output longint c);
		logic [31:0] u;
		bit flip;
		longint x, y, z, nx;
		u = {ang, {(32 - AB){1'b0}}};
		flip = u[31] ^ u[30];
		if (flip) u = u + 32'h8000_0000;
		z = longint'(signed'(u));
		x = 64'd2608131496;
		y = 0;
		for (int i = 0; i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_step(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = sat_one(rnd(x, 32 - FB));
		s = sat_one(rnd(y, 32 - FB));
	endtask

	function automatic longint fmul(longint a, longint b);
		return sat_one(rnd(a * b, FB));
	endfunction

	function automatic longint fdot(longint a, longint b, longint c, longint d);
		return sat_one(rnd(a * b + c * d, FB));
	endfunction

	task automatic predict_matrix(input logic [AB-1:0] p, y, r, output matrix_t m);
		longint ps, pc, ys, yc, rs, rc, psys, psyc;
		angle_sincos(p, ps, pc);
		angle_sincos(y, ys, yc);
		angle_sincos(r, rs, rc);
		psys = fmul(ps, ys);
		psyc = fmul(ps, yc);
		m.m00 = elem_t'(fdot(rc, yc, rs, psys));
		m.m01 = elem_t'(fdot(-rs, yc, rc, psys));
		m.m02 = elem_t'(fmul(pc, ys));
		m.m10 = elem_t'(fmul(rs, pc));
		m.m11 = elem_t'(fmul(rc, pc));
		m.m12 = elem_t'(sat_one(-ps));
		m.m20 = elem_t'(fdot(-rc, ys, rs, psyc));
		m.m21 = elem_t'(fdot(rs, ys, rc, psyc));
		m.m22 = elem_t'(fmul(pc, yc));
	endtask

	// Offer one item, hold it until taken, then predict its matrix.
	task automatic send_angles(input logic [AB-1:0] p, y, r);
		matrix_t m;
		int gap;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pitch_angle <= p;
		yaw_angle <= y;
		roll_angle <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_matrix(p, y, r, m);
		expected_matrices.push_back(m);
		items_sent++;
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		drop_valid();
		while (expected_matrices.size() != 0) @(posedge clk);
	endtask

	// Directed corners: quadrant edges, zero, and top codes on each axis.
	task automatic test_corner_angles();
		logic [AB-1:0] c[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'hFFFF, 16'h3FFF, 16'h7FFF, 16'h0001};
		for (int i = 0; i < 8; i++) send_angles(c[i], 16'h0000, 16'h0000);
		for (int i = 0; i < 8; i++) send_angles(16'h0000, c[i], c[7 - i]);
		send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		send_angles(16'h5555, 16'hAAAA, 16'h5555);
		send_angles(16'h2000, 16'h6000, 16'hE000);
	endtask

	// Random angles with near-quadrant-edge values mixed in.
	task automatic test_random_angles(input int n);
		logic [AB-1:0] a[3];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 4) == 0)
					a[k] = AB'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 4) - 2);
				else
					a[k] = AB'($urandom);
			end
			send_angles(a[0], a[1], a[2]);
		end
	endtask

	// Stall the output long enough to fill the pipe while items keep coming.
	task automatic test_backpressure();
		sink_hold = 1'b1;
		test_random_angles(40);
		sink_hold = 1'b0;
		wait_drained();
	endtask

	// Run without idling on either side for the tail of the test.
	task automatic test_full_rate();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_random_angles(300);
	endtask

	// Output side: random idle bursts, or a long hold when asked.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (sink_hold) begin
				out_ready <= 1'b0;
				n = 0;
				while (n < 60) begin
					@(posedge clk);
					n++;
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each accepted matrix with the oldest prediction.
	always @(posedge clk) begin
		matrix_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			matrices_seen++;
			if (expected_matrices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected matrix %h", got);
			end else begin
				want = expected_matrices.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("matrix %0d mismatch: exp %h got %h", matrices_seen, want, got);
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_angles();
		wait_drained();
		test_backpressure();
		test_random_angles(1580);
		wait_drained();
		test_full_rate();
		wait_drained();
		repeat (LATENCY + 5) @(posedge clk);
		$display("Sent %0d angle triples, checked %0d matrices, incl. quadrant edges,",
			items_sent, matrices_seen);
		$display("a long output stall, a drain pause and a full-rate tail.");
		if (mismatches == 0 && expected_matrices.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
